[design/smdb_pkg.sv]
// ----------------------------------------------------------------------------
// smdb_pkg
// Shared types, constants and the log2 mantissa function for the spectrum
// magnitude to dB level converter.
// ----------------------------------------------------------------------------
package smdb_pkg;

  // round(200 * log10(2) * 2^24)
  localparam logic [29:0] LOG_SCALE_Q24 = 30'd1010089052;
  localparam int unsigned BASE_LEVEL_DB = 107;

  typedef enum logic [1:0] {
    REG_CAL_ERROR  = 2'd0,
    REG_MODE_CORR  = 2'd1,
    REG_RF_ATTEN   = 2'd2,
    REG_IF_ATTEN   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [4:0]  expo;
    logic [29:0] frac;
    logic        clip;
    logic        last;
  } norm_t;

  typedef struct packed {
    logic [32:0] lq;
    logic        clip;
    logic        last;
  } log_t;

  typedef struct packed {
    logic signed [15:0] level;
    logic               clip;
    logic               last;
  } res_t;

  // log2(1 + i/2^t) in Q30 by repeated squaring of a Q31 value.
  function automatic logic [30:0] log2_mant_q30(int unsigned i, int unsigned t);
    logic [63:0] x;
    logic [29:0] r;
    if (i >= (32'd1 << t)) begin
      return 31'h4000_0000;
    end
    x = (64'd1 << 31) + (64'(i) << (31 - t));
    r = '0;
    for (int k = 29; k >= 0; k--) begin
      x = (x * x) >> 31;
      if (x >= 64'h1_0000_0000) begin
        r[k] = 1'b1;
        x = x >> 1;
      end
    end
    return {1'b0, r};
  endfunction

endpackage

[design/smdb_cfg.sv]
// ----------------------------------------------------------------------------
// smdb_cfg
// Register file on the configuration port and the combined level offset in
// tenths of a dB with 20 fraction bits.
// ----------------------------------------------------------------------------
module smdb_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic signed [35:0] offset_q20
);

  logic signed [15:0] cal_error_q8;
  logic signed [15:0] mode_correction_q8;
  logic [4:0]         rf_atten_db;
  logic [4:0]         if_atten_db;
  logic signed [17:0] off_q8;
  logic [7:0]         atten_sum;
  smdb_pkg::reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = smdb_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_error_q8       <= '0;
      mode_correction_q8 <= '0;
      rf_atten_db        <= '0;
      if_atten_db        <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        smdb_pkg::REG_CAL_ERROR: cal_error_q8       <= pwdata[15:0];
        smdb_pkg::REG_MODE_CORR: mode_correction_q8 <= pwdata[15:0];
        smdb_pkg::REG_RF_ATTEN:  rf_atten_db        <= pwdata[4:0];
        smdb_pkg::REG_IF_ATTEN:  if_atten_db        <= pwdata[4:0];
        default:                 cal_error_q8       <= cal_error_q8;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      smdb_pkg::REG_CAL_ERROR: prdata = 32'(cal_error_q8);
      smdb_pkg::REG_MODE_CORR: prdata = 32'(mode_correction_q8);
      smdb_pkg::REG_RF_ATTEN:  prdata = {27'b0, rf_atten_db};
      smdb_pkg::REG_IF_ATTEN:  prdata = {27'b0, if_atten_db};
      default:                 prdata = '0;
    endcase
  end

  // The offset is Q8 dB times ten times 2^12, which is a shift by 15 plus a shift by 13.
  always_comb begin
    atten_sum = 8'(rf_atten_db) + 8'(if_atten_db) + 8'(smdb_pkg::BASE_LEVEL_DB);
    off_q8    = 18'(mode_correction_q8) - 18'(cal_error_q8) + $signed({2'b0, atten_sum, 8'b0});
  end

  always_ff @(posedge clk) begin
    offset_q20 <= (36'(off_q8) <<< 15) + (36'(off_q8) <<< 13);
  end

endmodule

[design/smdb_norm.sv]
// ----------------------------------------------------------------------------
// smdb_norm
// Replaces nonpositive magnitudes by one, finds the leading one and
// normalizes the magnitude into exponent and 30-bit fraction.
// ----------------------------------------------------------------------------
module smdb_norm (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         magnitude,
  input  logic                frame_end,
  output logic                out_valid,
  input  logic                out_ready,
  output smdb_pkg::norm_t     out_data
);

  localparam int Stages = 2;

  logic [Stages-1:0] vld;
  logic [Stages-1:0] en;
  logic [30:0]       mag1;
  logic              clip1;
  logic              last1;
  logic [4:0]        lead;
  logic [30:0]       shifted;

  always_comb begin
    en[Stages-1] = !vld[Stages-1] || out_ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[Stages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      if (magnitude[31] || magnitude == 32'd0) begin
        mag1  <= 31'd1;
        clip1 <= 1'b1;
      end else begin
        mag1  <= magnitude[30:0];
        clip1 <= 1'b0;
      end
      last1 <= frame_end;
    end
  end

  always_comb begin
    lead = '0;
    for (int b = 0; b < 31; b++) begin
      if (mag1[b]) begin
        lead = 5'(b);
      end
    end
    shifted = mag1 << (5'd30 - lead);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      out_data.expo <= lead;
      out_data.frac <= shifted[29:0];
      out_data.clip <= clip1;
      out_data.last <= last1;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    vld[1] && out_data.expo == 5'd0 |-> out_data.frac == 30'd0)
    else $error("smdb_norm: fraction left over for a unit magnitude");
`endif

endmodule

[design/smdb_log2.sv]
// ----------------------------------------------------------------------------
// smdb_log2
// Base-2 logarithm, output in Q28, from exponent and fraction: mantissa table lookup
// and linear interpolation between neighboring entries.
// ----------------------------------------------------------------------------
module smdb_log2 #(
  parameter int T = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  smdb_pkg::norm_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output smdb_pkg::log_t  out_data
);

  localparam int Stages = 4;
  localparam int Sh     = 30 - T;
  localparam int Depth  = (2 ** T) + 1;
  localparam int ProdW  = 31 + Sh;

  logic [30:0]       mant_tab [Depth];

  logic [Stages-1:0] vld;
  logic [Stages-1:0] en;
  logic [T:0]        addr0;
  logic [T:0]        addr1;

  logic [30:0]       rd0_a;
  logic [30:0]       rd1_a;
  logic [Sh-1:0]     rem_a;
  logic [4:0]        expo_a;
  logic              clip_a;
  logic              last_a;

  logic [30:0]       diff_b;
  logic [30:0]       base_b;
  logic [Sh-1:0]     rem_b;
  logic [4:0]        expo_b;
  logic              clip_b;
  logic              last_b;

  logic [ProdW-1:0]  prod;
  logic [30:0]       interp_c;
  logic [30:0]       base_c;
  logic [4:0]        expo_c;
  logic              clip_c;
  logic              last_c;

  logic [34:0]       l30;

  for (genvar gi = 0; gi < Depth; gi++) begin : g_mant_tab
    localparam logic [30:0] Entry = smdb_pkg::log2_mant_q30(gi, T);
    assign mant_tab[gi] = Entry;
  end

  always_comb begin
    en[Stages-1] = !vld[Stages-1] || out_ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[Stages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign addr0 = {1'b0, in_data.frac[29 -: T]};
  assign addr1 = addr0 + 1'b1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rd0_a  <= mant_tab[addr0];
      rd1_a  <= mant_tab[addr1];
      rem_a  <= in_data.frac[Sh-1:0];
      expo_a <= in_data.expo;
      clip_a <= in_data.clip;
      last_a <= in_data.last;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      diff_b <= rd1_a - rd0_a;
      base_b <= rd0_a;
      rem_b  <= rem_a;
      expo_b <= expo_a;
      clip_b <= clip_a;
      last_b <= last_a;
    end
  end

  assign prod = ProdW'(diff_b) * ProdW'(rem_b);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      interp_c <= prod[Sh +: 31];
      base_c   <= base_b;
      expo_c   <= expo_b;
      clip_c   <= clip_b;
      last_c   <= last_b;
    end
  end

  assign l30 = {expo_c, 30'b0} + 35'(base_c) + 35'(interp_c);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      out_data.lq   <= l30[34:2];
      out_data.clip <= clip_c;
      out_data.last <= last_c;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> rd1_a >= rd0_a)
    else $error("smdb_log2: mantissa table read out of order");
`endif

endmodule

[design/smdb_scale.sv]
// ----------------------------------------------------------------------------
// smdb_scale
// Scales log2 to tenths of a dB, adds the level offset, rounds half away
// from zero and saturates to 16 bits.
// ----------------------------------------------------------------------------
module smdb_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  smdb_pkg::log_t     in_data,
  input  logic signed [35:0] offset_q20,
  output logic               out_valid,
  input  logic               out_ready,
  output smdb_pkg::res_t     out_data
);

  localparam int Stages = 3;

  logic [Stages-1:0]  vld;
  logic [Stages-1:0]  en;

  logic [46:0]        pp_lo;
  logic [45:0]        pp_hi;
  logic               clip1;
  logic               last1;

  logic [62:0]        prod;
  logic signed [35:0] total;
  logic               clip2;
  logic               last2;

  logic               neg;
  logic [35:0]        abs_total;
  logic [36:0]        rnd;
  logic signed [17:0] level_w;

  always_comb begin
    en[Stages-1] = !vld[Stages-1] || out_ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[Stages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp_lo <= {30'b0, in_data.lq[16:0]} * {17'b0, smdb_pkg::LOG_SCALE_Q24};
      pp_hi <= {30'b0, in_data.lq[32:17]} * {16'b0, smdb_pkg::LOG_SCALE_Q24};
      clip1 <= in_data.clip;
      last1 <= in_data.last;
    end
  end

  assign prod = {pp_hi, 17'b0} + {16'b0, pp_lo};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      total <= $signed({5'b0, prod[62:32]}) + offset_q20;
      clip2 <= clip1;
      last2 <= last1;
    end
  end

  always_comb begin
    neg       = total[35];
    abs_total = neg ? 36'(-total) : 36'(total);
    rnd       = 37'(abs_total) + (37'd1 << 19);
    level_w   = neg ? -$signed({1'b0, rnd[36:20]}) : $signed({1'b0, rnd[36:20]});
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      out_data.last <= last2;
      if (level_w > 18'sd32767) begin
        out_data.level <= 16'sh7FFF;
        out_data.clip  <= 1'b1;
      end else if (level_w < -18'sd32768) begin
        out_data.level <= 16'sh8000;
        out_data.clip  <= 1'b1;
      end else begin
        out_data.level <= level_w[15:0];
        out_data.clip  <= clip2;
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    vld[0] && !en[0] |=> vld[0] && $stable(pp_hi) && $stable(pp_lo))
    else $error("smdb_scale: stalled partial products changed");
  assert property (@(posedge clk) disable iff (rst)
    vld[2] && (out_data.level == 16'sh7FFF || out_data.level == 16'sh8000) && !out_data.clip
    |-> 1'b0)
    else $error("smdb_scale: saturated level without clip flag");
`endif

endmodule

[design/spectrum_magnitude_to_db_level.sv]
// ----------------------------------------------------------------------------
// spectrum_magnitude_to_db_level
// Converts spectrum bin magnitudes to levels in tenths of a dB, with frame
// end pass-through and a clip flag.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle unless m_tready holds the output; nine
// pipeline stages, each with a valid bit. Reset clears every valid bit and
// the four configuration registers; the mantissa table is a constant ROM
// and needs no fill.
module spectrum_magnitude_to_db_level #(
  parameter int LOG_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] magnitude
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] level_tenths_db
  output logic        m_tlast,
  output logic        m_tuser,   // [0] clipped
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               norm_valid;
  logic               norm_ready;
  smdb_pkg::norm_t    norm_data;
  logic               log_valid;
  logic               log_ready;
  smdb_pkg::log_t     log_data;
  smdb_pkg::res_t     res_data;
  logic signed [35:0] offset_q20;

  smdb_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .offset_q20 (offset_q20)
  );

  smdb_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .magnitude (s_tdata),
    .frame_end (s_tlast),
    .out_valid (norm_valid),
    .out_ready (norm_ready),
    .out_data  (norm_data)
  );

  smdb_log2 #(
    .T (LOG_TABLE_BITS)
  ) u_log2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (norm_valid),
    .in_ready  (norm_ready),
    .in_data   (norm_data),
    .out_valid (log_valid),
    .out_ready (log_ready),
    .out_data  (log_data)
  );

  smdb_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (log_valid),
    .in_ready   (log_ready),
    .in_data    (log_data),
    .offset_q20 (offset_q20),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (res_data)
  );

  assign m_tdata = res_data.level;
  assign m_tlast = res_data.last;
  assign m_tuser = res_data.clip;

endmodule
